// ----- src/rmbd_pkg.sv -----
// Shared constants for the range-minimum block decomposition.
// Field widths, register reset value, default sizes and command codes.
// No dependencies.
package rmbd_pkg;

    localparam int POS_W       = 10;
    localparam int CNT_W       = 11;
    localparam int DEPTH_DEF   = 1024;
    localparam int BLOCK_DEF   = 32;
    localparam int VALUE_W_DEF = 32;

    localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

endpackage

// ----- src/rmbd_div.sv -----
// Position divided by the constant block length, by reciprocal multiplication.
// Quotient and remainder are registered; done is registered from start and follows it in the next cycle.
// Depends on rmbd_pkg.
module rmbd_div #(
    parameter int BLOCK = rmbd_pkg::BLOCK_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rmbd_pkg::POS_W-1:0]    dividend,
    output logic                          done,
    output logic [rmbd_pkg::POS_W-1:0]    quotient,
    output logic [$clog2(BLOCK)-1:0]      remainder
);
    import rmbd_pkg::*;

    localparam int R_W    = $clog2(BLOCK);
    localparam int SHIFT  = POS_W + R_W;
    localparam int MUL_W  = POS_W + 2;
    localparam int PROD_W = SHIFT + POS_W;
    localparam logic [MUL_W-1:0] RECIP = MUL_W'(((1 << SHIFT) + BLOCK - 1) / BLOCK);

    logic [PROD_W-1:0] prod;
    logic [POS_W-1:0]  quo;
    logic [POS_W-1:0]  back;
    logic [R_W-1:0]    rem;
    logic [POS_W-1:0]  quo_reg;
    logic [R_W-1:0]    rem_reg;
    logic              done_reg;

    assign prod = PROD_W'(dividend) * PROD_W'(RECIP);
    assign quo  = prod[SHIFT +: POS_W];
    assign back = POS_W'(quo * BLOCK);
    assign rem  = R_W'(dividend - back);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= start;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= quo;
            rem_reg <= rem;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- src/rmbd_ram.sv -----
// Single-port synchronous RAM with registered read data (read-first).
// Holds the element store and the block minimums.
// No dependencies.
module rmbd_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/rmbd_min.sv -----
// Shared signed-minimum accumulator used by both scans.
// Clear loads the largest value; each enabled cycle folds in one word.
// No dependencies.
module rmbd_min #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          clear,
    input  logic                          en,
    input  logic signed [VALUE_WIDTH-1:0] din,
    output logic signed [VALUE_WIDTH-1:0] acc
);

    localparam logic signed [VALUE_WIDTH-1:0] LARGEST = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    logic signed [VALUE_WIDTH-1:0] acc_reg;

    always_ff @(posedge aclk) begin
        if (clear) begin
            acc_reg <= LARGEST;
        end else if (en && (din < acc_reg)) begin
            acc_reg <= din;
        end
    end

    assign acc = acc_reg;

endmodule

// ----- src/range_min_block_decomposition.sv -----
// Range-minimum block decomposition: sequencer, element RAM, block-minimum RAM.
// A bad position goes straight to a flagged result. A query runs divide, scan, drain and
// finish, one RAM read per edge element or whole block; a write runs divide, element
// store, block rescan, drain and block write. One item at a time: next item after the
// result or the rescan. After reset a clearing pass fills both RAMs; no item is taken
// meanwhile, configuration writes are. Reset is synchronous, active low.
module range_min_block_decomposition #(
    parameter int DEPTH       = rmbd_pkg::DEPTH_DEF,
    parameter int BLOCK       = rmbd_pkg::BLOCK_DEF,
    parameter int VALUE_WIDTH = rmbd_pkg::VALUE_W_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [rmbd_pkg::POS_W-1:0]    s_position,
    input  logic [rmbd_pkg::POS_W-1:0]    s_right_end,
    input  logic signed [VALUE_WIDTH-1:0] s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [VALUE_WIDTH-1:0] m_range_min,
    output logic                          m_position_bad,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rmbd_pkg::CNT_W-1:0]    cfg_data
);
    import rmbd_pkg::*;

    localparam int NUM_GROUPS  = (DEPTH + BLOCK - 1) / BLOCK;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int GA_W        = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int IDX_W       = POS_W + 1;
    localparam int R_W         = $clog2(BLOCK);
    localparam int SPAN_W      = $clog2((1 << POS_W) + BLOCK) + 1;
    localparam int DEPTH_CLAMP = (DEPTH < 2047) ? DEPTH : 2047;
    localparam logic signed [VALUE_WIDTH-1:0] LARGEST = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_DIV    = 8'b0000_0100,
        ST_WSTORE = 8'b0000_1000,
        ST_SCAN   = 8'b0001_0000,
        ST_DRAIN  = 8'b0010_0000,
        ST_BWRITE = 8'b0100_0000,
        ST_FIN    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              cnt;
    logic [CNT_W-1:0]              cnt_m1;
    logic [ADDR_W-1:0]             clr_idx_reg;
    logic                          clr_done;
    logic                          clr_blk;

    logic                          cmd_reg;
    logic [POS_W-1:0]              pos_reg;
    logic [POS_W-1:0]              rgt_reg;
    logic signed [VALUE_WIDTH-1:0] val_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic [POS_W-1:0]              hi_reg;
    logic [POS_W-1:0]              q_cur_reg;
    logic [R_W-1:0]                r_cur_reg;
    logic                          rd_pend_reg;
    logic                          rd_blk_reg;

    logic                          m_valid_reg;
    logic signed [VALUE_WIDTH-1:0] m_min_reg;
    logic                          m_bad_reg;

    logic                          accept;
    logic                          in_bad;
    logic                          out_free;
    logic                          q_mode;
    logic                          in_range;
    logic                          whole;
    logic [POS_W-1:0]              lo;
    logic [SPAN_W-1:0]             lo_plus;
    logic [POS_W-1:0]              hi_calc;

    logic                          div_done;
    logic [POS_W-1:0]              div_quo;
    logic [R_W-1:0]                div_rem;

    logic                          elem_we;
    logic [ADDR_W-1:0]             elem_addr;
    logic [VALUE_WIDTH-1:0]        elem_wdata;
    logic [VALUE_WIDTH-1:0]        elem_rdata;
    logic                          blk_we;
    logic [GA_W-1:0]               blk_addr;
    logic [VALUE_WIDTH-1:0]        blk_wdata;
    logic [VALUE_WIDTH-1:0]        blk_rdata;

    logic                          min_clear;
    logic signed [VALUE_WIDTH-1:0] min_din;
    logic signed [VALUE_WIDTH-1:0] min_acc;

    assign cnt    = (count_reg > CNT_W'(DEPTH_CLAMP)) ? CNT_W'(DEPTH_CLAMP) : count_reg;
    assign cnt_m1 = cnt - CNT_W'(1);

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign in_bad    = ({1'b0, s_position} >= cnt) ||
                       ((s_command == CMD_QUERY) && ({1'b0, s_right_end} >= cnt));

    assign clr_done = clr_idx_reg == ADDR_W'(DEPTH - 1);
    assign clr_blk  = {1'b0, clr_idx_reg} < (ADDR_W+1)'(NUM_GROUPS);

    assign q_mode   = cmd_reg == CMD_QUERY;
    assign in_range = q_mode ? (idx_reg <= {1'b0, rgt_reg}) : (idx_reg <= {1'b0, hi_reg});
    assign whole    = q_mode && (r_cur_reg == '0) &&
                      (SPAN_W'(idx_reg) + SPAN_W'(BLOCK - 1) <= SPAN_W'(rgt_reg));

    assign lo      = pos_reg - POS_W'(r_cur_reg);
    assign lo_plus = SPAN_W'(lo) + SPAN_W'(BLOCK - 1);
    assign hi_calc = (lo_plus > SPAN_W'(cnt_m1)) ? POS_W'(cnt_m1) : POS_W'(lo_plus);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_done) state_next = ST_IDLE;
            ST_IDLE:   if (accept && !in_bad) state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = q_mode ? ST_SCAN : ST_WSTORE;
            ST_WSTORE: state_next = ST_SCAN;
            ST_SCAN:   if (!in_range) state_next = ST_DRAIN;
            ST_DRAIN:  state_next = q_mode ? ST_FIN : ST_BWRITE;
            ST_BWRITE: state_next = ST_IDLE;
            ST_FIN:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            count_reg   <= COUNT_RESET;
            clr_idx_reg <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == ST_SCAN) && in_range;
            if (cfg_valid) begin
                count_reg <= cfg_data;
            end
            if (state_reg == ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + ADDR_W'(1);
            end
            if ((accept && in_bad) || ((state_reg == ST_FIN) && out_free)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_blk_reg <= whole;
        if (accept) begin
            cmd_reg <= s_command;
            pos_reg <= s_position;
            rgt_reg <= s_right_end;
            val_reg <= s_value;
        end
        if (accept && in_bad) begin
            m_min_reg <= LARGEST;
            m_bad_reg <= 1'b1;
        end else if ((state_reg == ST_FIN) && out_free) begin
            m_min_reg <= min_acc;
            m_bad_reg <= 1'b0;
        end
        if ((state_reg == ST_DIV) && div_done) begin
            q_cur_reg <= div_quo;
            r_cur_reg <= div_rem;
            idx_reg   <= IDX_W'(pos_reg);
        end else if (state_reg == ST_WSTORE) begin
            idx_reg <= {1'b0, lo};
            hi_reg  <= hi_calc;
        end else if ((state_reg == ST_SCAN) && in_range) begin
            if (whole) begin
                idx_reg   <= IDX_W'(SPAN_W'(idx_reg) + SPAN_W'(BLOCK));
                q_cur_reg <= q_cur_reg + POS_W'(1);
            end else begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (q_mode) begin
                    if (r_cur_reg == R_W'(BLOCK - 1)) begin
                        r_cur_reg <= '0;
                        q_cur_reg <= q_cur_reg + POS_W'(1);
                    end else begin
                        r_cur_reg <= r_cur_reg + R_W'(1);
                    end
                end
            end
        end
    end

    // element store: cleared, written at the write position, read by the scan
    always_comb begin
        elem_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WSTORE);
        elem_wdata = (state_reg == ST_CLEAR) ? LARGEST : val_reg;
        if (state_reg == ST_CLEAR) begin
            elem_addr = clr_idx_reg;
        end else if (state_reg == ST_WSTORE) begin
            elem_addr = ADDR_W'(pos_reg);
        end else begin
            elem_addr = ADDR_W'(idx_reg);
        end
    end

    assign blk_we    = ((state_reg == ST_CLEAR) && clr_blk) || (state_reg == ST_BWRITE);
    assign blk_addr  = (state_reg == ST_CLEAR) ? GA_W'(clr_idx_reg) : GA_W'(q_cur_reg);
    assign blk_wdata = (state_reg == ST_CLEAR) ? LARGEST : min_acc;

    assign min_clear = ((state_reg == ST_DIV) && div_done && q_mode) ||
                       (state_reg == ST_WSTORE);
    assign min_din   = rd_blk_reg ? $signed(blk_rdata) : $signed(elem_rdata);

    rmbd_div #(
        .BLOCK(BLOCK)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept && !in_bad),
        .dividend (s_position),
        .done     (div_done),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    rmbd_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_elem_ram (
        .aclk (aclk),
        .we   (elem_we),
        .addr (elem_addr),
        .wdata(elem_wdata),
        .rdata(elem_rdata)
    );

    rmbd_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (NUM_GROUPS),
        .ADDR_W(GA_W)
    ) u_blk_ram (
        .aclk (aclk),
        .we   (blk_we),
        .addr (blk_addr),
        .wdata(blk_wdata),
        .rdata(blk_rdata)
    );

    rmbd_min #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_min (
        .aclk (aclk),
        .clear(min_clear),
        .en   (rd_pend_reg),
        .din  (min_din),
        .acc  (min_acc)
    );

    assign m_valid        = m_valid_reg;
    assign m_range_min    = m_min_reg;
    assign m_position_bad = m_bad_reg;

endmodule

// ----- src/rmbd_checker.sv -----
// Port-level checks for range_min_block_decomposition, bound to the top level.
// Depends on rmbd_pkg.
module rmbd_props #(
    parameter int VALUE_WIDTH = rmbd_pkg::VALUE_W_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_command,
    input logic [rmbd_pkg::POS_W-1:0]    s_position,
    input logic [rmbd_pkg::POS_W-1:0]    s_right_end,
    input logic signed [VALUE_WIDTH-1:0] s_value,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [VALUE_WIDTH-1:0] m_range_min,
    input logic                          m_position_bad,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [rmbd_pkg::CNT_W-1:0]    cfg_data
);
    import rmbd_pkg::*;

    localparam logic signed [VALUE_WIDTH-1:0] LARGEST = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    // reset starts the clearing pass: no item taken, no result shown
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("item taken or result shown right after reset");

    a_bad_is_largest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_position_bad |-> m_range_min == LARGEST)
        else $error("flagged item carries a value other than the largest");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_range_min) && $stable(m_position_bad))
        else $error("stalled result item changed");

    a_in_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !$isunknown({s_command, s_position, s_right_end, s_value}))
        else $error("accepted item carries unknown bits");

    a_cfg_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready && !$isunknown(cfg_data))
        else $error("register write not taken or unknown");

endmodule

bind range_min_block_decomposition rmbd_props #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_rmbd_props (.*);

// ----- tb/rmbd_checker.sv -----
// Checker for the range-minimum block decomposition: watches the item, result and
// register channels, keeps its own copy of the element and block-minimum stores,
// predicts each result and compares it. Depends on rmbd_pkg.
module rmbd_checker #(
    parameter int DEPTH = rmbd_pkg::DEPTH_DEF,
    parameter int BLOCK = rmbd_pkg::BLOCK_DEF,
    parameter int VW    = rmbd_pkg::VALUE_W_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic                       s_command,
    input  logic [rmbd_pkg::POS_W-1:0] s_position,
    input  logic [rmbd_pkg::POS_W-1:0] s_right_end,
    input  logic signed [VW-1:0]       s_value,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [VW-1:0]       m_range_min,
    input  logic                       m_position_bad,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [rmbd_pkg::CNT_W-1:0] cfg_data,
    output int                         errors,
    output int                         pending,
    output int                         results_seen,
    output int                         bad_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import rmbd_pkg::*;

    localparam int GROUPS = (DEPTH + BLOCK - 1) / BLOCK;
    localparam logic signed [VW-1:0] LARGEST = {1'b0, {(VW-1){1'b1}}};

    typedef struct packed {
        logic signed [VW-1:0] range_min;
        logic                 position_bad;
    } min_result_t;

    logic signed [VW-1:0] elem_store [DEPTH];
    logic signed [VW-1:0] group_min [GROUPS];
    logic [CNT_W-1:0]     count_in_use;
    min_result_t          expected_mins [$];

    function automatic int active_count();
        return (count_in_use > DEPTH) ? DEPTH : int'(count_in_use);
    endfunction

    task automatic apply_item(input logic cmd, input int pos, input int rgt,
                              input logic signed [VW-1:0] val);
        int cnt, lo, hi, i;
        logic signed [VW-1:0] m;
        min_result_t res;
        cnt = active_count();
        res = '{range_min: LARGEST, position_bad: 1'b1};
        if (cmd == CMD_WRITE) begin
            if (pos >= cnt) begin
                expected_mins = {expected_mins, res};
            end else begin
                elem_store[pos] = val;
                lo = (pos / BLOCK) * BLOCK;
                hi = lo + BLOCK - 1;
                if (hi > cnt - 1)
                    hi = cnt - 1;
                m = LARGEST;
                for (i = lo; i <= hi; i++)
                    if (elem_store[i] < m)
                        m = elem_store[i];
                group_min[pos / BLOCK] = m;
            end
        end else begin
            if (pos < cnt && rgt < cnt) begin
                m = LARGEST;
                i = pos;
                while (i <= rgt) begin
                    if (i % BLOCK == 0 && i + BLOCK - 1 <= rgt) begin
                        if (group_min[i / BLOCK] < m)
                            m = group_min[i / BLOCK];
                        i += BLOCK;
                    end else begin
                        if (elem_store[i] < m)
                            m = elem_store[i];
                        i++;
                    end
                end
                res = '{range_min: m, position_bad: 1'b0};
            end
            expected_mins = {expected_mins, res};
        end
    endtask

    always @(posedge aclk) begin
        min_result_t want;
        if (!aresetn) begin
            count_in_use = COUNT_RESET;
            for (int i = 0; i < DEPTH; i++)
                elem_store[i] = LARGEST;
            for (int g = 0; g < GROUPS; g++)
                group_min[g] = LARGEST;
            expected_mins.delete();
            errors = 0;
            results_seen = 0;
            bad_seen = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_position_bad)
                    bad_seen++;
                if (expected_mins.size() == 0) begin
                    errors++;
                    $error("result item with nothing expected: range_min %0d position_bad %0b",
                           m_range_min, m_position_bad);
                end else begin
                    want = expected_mins.pop_front();
                    if (m_range_min !== want.range_min) begin
                        errors++;
                        $error("range_min: expected %0d, actual %0d",
                               want.range_min, m_range_min);
                    end
                    if (m_position_bad !== want.position_bad) begin
                        errors++;
                        $error("position_bad: expected %0b, actual %0b",
                               want.position_bad, m_position_bad);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                count_in_use = cfg_data;
            if (s_valid && s_ready)
                apply_item(s_command, int'(s_position), int'(s_right_end), s_value);
        end
        pending <= expected_mins.size();
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the range-minimum block decomposition testbench: clock, reset, item and
// register stimulus, result-side stalls and the verdict. Depends on rmbd_pkg,
// range_min_block_decomposition and rmbd_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rmbd_pkg::*;

    localparam int DEPTH           = DEPTH_DEF;
    localparam int VW              = VALUE_W_DEF;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int LATENCY_PAD     = 120;
    localparam int HOLD_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 1_500_000;
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(DEPTH - 1);

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_command = CMD_WRITE;
    logic [POS_W-1:0]     s_position = '0;
    logic [POS_W-1:0]     s_right_end = '0;
    logic signed [VW-1:0] s_value = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [VW-1:0] m_range_min;
    logic                 m_position_bad;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CNT_W-1:0]     cfg_data = COUNT_RESET;

    int errors, pending, results_seen, bad_seen;
    int cycles;
    int n_writes, n_queries, n_settings;
    int hold_req, holds_done;
    bit tx_idle, rx_idle;
    logic [CNT_W-1:0] cur_count = COUNT_RESET;

    range_min_block_decomposition u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_position     (s_position),
        .s_right_end    (s_right_end),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_range_min    (m_range_min),
        .m_position_bad (m_position_bad),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    rmbd_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_position     (s_position),
        .s_right_end    (s_right_end),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_range_min    (m_range_min),
        .m_position_bad (m_position_bad),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .errors         (errors),
        .pending        (pending),
        .results_seen   (results_seen),
        .bad_seen       (bad_seen)
    );

    always #5 aclk = ~aclk;

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stall bursts, plus the long hold-off on request
    initial begin
        @(posedge aclk);
        forever begin
            if (holds_done != hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_done++;
            end else if (rx_idle && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [POS_W-1:0] pos,
                             input logic [POS_W-1:0] rgt, input logic signed [VW-1:0] val);
        if (tx_idle && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_position  <= pos;
        s_right_end <= rgt;
        s_value     <= val;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (cmd == CMD_WRITE)
            n_writes++;
        else
            n_queries++;
    endtask

    // drain: all results back, then room for a write still rescanning its block
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (LATENCY_PAD) @(posedge aclk);
    endtask

    task automatic set_count(input logic [CNT_W-1:0] c);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        cur_count = c;
        n_settings++;
    endtask

    function automatic logic [CNT_W-1:0] pick_count(input int ph);
        if (ph == 0)
            return CNT_W'(1);
        case ($urandom_range(0, 9))
            0: return CNT_W'(1);
            1: return COUNT_RESET;
            2: return {CNT_W{1'b1}};
            3: return CNT_W'($urandom_range(DEPTH + 1, 2047));
            4, 5: return CNT_W'($urandom_range(2, 64));
            default: return CNT_W'($urandom_range(1, DEPTH));
        endcase
    endfunction

    task automatic random_item();
        int lim, p, r;
        logic cmd;
        logic signed [VW-1:0] v;
        lim = (cur_count > DEPTH) ? DEPTH : int'(cur_count);
        cmd = ($urandom_range(0, 1) == 0) ? CMD_WRITE : CMD_QUERY;
        if (lim == 0 || $urandom_range(0, 9) == 0)
            p = $urandom_range(0, DEPTH - 1);
        else
            p = $urandom_range(0, lim - 1);
        case ($urandom_range(0, 7))
            0: r = $urandom_range(0, DEPTH - 1);
            1: r = (p > 0) ? $urandom_range(0, p - 1) : 0;
            2, 3, 4: begin
                r = p + $urandom_range(0, 40);
                if (lim > 0 && r >= lim)
                    r = lim - 1;
            end
            default: r = (p < lim) ? $urandom_range(p, lim - 1) : p;
        endcase
        if (r > DEPTH - 1)
            r = DEPTH - 1;
        case ($urandom_range(0, 7))
            0: v = VMIN;
            1: v = VMAX;
            2: v = $urandom_range(0, 200) - 100;
            default: v = $urandom();
        endcase
        send_item(cmd, p[POS_W-1:0], r[POS_W-1:0], v);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: untouched store, extremes, block edges, empty and bad ranges
        set_count(COUNT_RESET);
        send_item(CMD_QUERY, 0, LAST_POS, 0);
        send_item(CMD_WRITE, 0, 0, VMIN);
        send_item(CMD_WRITE, LAST_POS, LAST_POS, VMAX);
        send_item(CMD_WRITE, 31, 0, 0);
        send_item(CMD_WRITE, 32, 0, -1);
        send_item(CMD_WRITE, 63, 0, -7);
        send_item(CMD_WRITE, 500, 0, 12345);
        send_item(CMD_QUERY, 0, LAST_POS, 0);
        send_item(CMD_QUERY, 1, LAST_POS - POS_W'(1), 0);
        send_item(CMD_QUERY, 32, 63, 0);
        send_item(CMD_QUERY, 5, 3, 0);
        send_item(CMD_QUERY, LAST_POS, LAST_POS, 0);
        set_count(40);
        send_item(CMD_WRITE, 40, 0, 1);
        send_item(CMD_WRITE, LAST_POS, 0, 1);
        send_item(CMD_QUERY, 0, 40, 0);
        send_item(CMD_QUERY, 40, 0, 0);
        send_item(CMD_WRITE, 39, 0, 9);
        send_item(CMD_QUERY, 0, 39, 0);
        // block 1 minimum was rebuilt over 32..39 only; it stays stale
        set_count({CNT_W{1'b1}});
        send_item(CMD_QUERY, 32, 63, 0);
        send_item(CMD_QUERY, 33, 63, 0);
        set_count(0);
        send_item(CMD_WRITE, 0, 0, 5);
        send_item(CMD_QUERY, 0, 0, 0);

        for (int ph = 0; ph < PHASES; ph++) begin
            set_count(pick_count(ph));
            tx_idle = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
            rx_idle = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == 2 && k == 20)
                    hold_req++;
                random_item();
            end
        end
        settle();

        $display("Sent %0d writes and %0d queries under %0d count settings.",
                 n_writes, n_queries, n_settings);
        $display("Checked %0d result items, %0d of them flagging a bad position.",
                 results_seen, bad_seen);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
